// ----- rtl/core/framed_packet_receiver_core_macros.svh -----
// assertion macros shared by the framed packet receiver rtl
`ifndef FRAMED_PACKET_RECEIVER_CORE_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication or plain property
`define FPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("framed packet receiver assertion failed");
// condition in one cycle, consequence in the next
`define FPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framed packet receiver assertion failed");
`else
`define FPR_ASSERT(lbl, clk, rst, prop)
`define FPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/fpr_pkg.sv -----
// types, codes and constants of the framed packet receiver
package fpr_pkg;

  // opcodes of an input item
  localparam logic [1:0] OP_RX          = 2'd0;
  localparam logic [1:0] OP_CLR_DISCARD = 2'd1;
  localparam logic [1:0] OP_CLR_MASTER  = 2'd2;
  localparam logic [1:0] OP_CLR_SLAVE   = 2'd3;

  // byte status codes
  localparam logic [2:0] ST_IN_FRAME  = 3'd0;
  localparam logic [2:0] ST_ACCEPT    = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_CMD   = 3'd4;
  localparam logic [2:0] ST_BAD_CHECK = 3'd5;
  localparam logic [2:0] ST_BAD_END   = 3'd6;

  // register indexes on the config port
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  localparam logic [7:0] LEN_MIN       = 8'd3;
  localparam logic [7:0] CMD_FLOOR     = 8'h30;
  localparam logic [7:0] CMD_SLAVE_A   = 8'h99;
  localparam logic [7:0] LEN_SLAVE_A   = 8'd3;
  localparam logic [7:0] CMD_SLAVE_B   = 8'h9A;
  localparam logic [7:0] LEN_SLAVE_B   = 8'd5;
  localparam logic [7:0] CMD_SLAVE_MIN = 8'hA0;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  byte_status;
    logic        from_slave;
    logic [7:0]  command_code;
    logic [7:0]  frame_length;
    logic [31:0] discarded_bytes;
    logic [31:0] master_frames;
    logic [31:0] slave_frames;
  } result_t;

  function automatic logic is_slave(input logic [7:0] cmd, input logic [7:0] len);
    logic r;
    if (cmd == CMD_SLAVE_A) begin
      r = (len == LEN_SLAVE_A);
    end else if (cmd == CMD_SLAVE_B) begin
      r = (len == LEN_SLAVE_B);
    end else begin
      r = (cmd >= CMD_SLAVE_MIN);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/framed_packet_receiver_core.sv -----
// top level of the framed packet receiver: input stage, parser, result register
//
//  channel   direction  handshake            payload
//  config    in         psel/penable/pready  paddr, pwdata, pwrite; prdata back
//  input     in         in_valid/in_ready    opcode, rx_byte
//  result    out        out_valid/out_ready  byte_status .. slave_frames
//
// one item per clock sustained while the result is not stalled; an item is held in the
// input stage register, and its result is then taken into the result register
// parser state and counters update when the item moves from input stage to result
// register, so the per-byte logic (xor, compare, 32-bit add) sets the clock path
// reset clears parser state, counters, config registers and both valid flags
// a stalled result holds the input stage; in_ready drops only when both are full
module framed_packet_receiver_core import fpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_status,
  output logic        from_slave,
  output logic [7:0]  command_code,
  output logic [7:0]  frame_length,
  output logic [31:0] discarded_bytes,
  output logic [31:0] master_frames,
  output logic [31:0] slave_frames
);
  `include "framed_packet_receiver_core_macros.svh"

  cfg_t       cfg;
  logic       s1_valid;
  logic [1:0] s1_opcode;
  logic [7:0] s1_byte;
  logic       commit;
  result_t    res;
  result_t    out_res;

  fpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpr_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .commit  (commit),
    .opcode  (s1_opcode),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .res     (res)
  );

  assign commit   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_byte   <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res <= res;
    end
  end

  assign byte_status     = out_res.byte_status;
  assign from_slave      = out_res.from_slave;
  assign command_code    = out_res.command_code;
  assign frame_length    = out_res.frame_length;
  assign discarded_bytes = out_res.discarded_bytes;
  assign master_frames   = out_res.master_frames;
  assign slave_frames    = out_res.slave_frames;

  // slave flag only rides on an accepted frame
  `FPR_ASSERT(a_slave_on_accept, clk, rst, out_valid && from_slave |-> byte_status == ST_ACCEPT)
  // back-pressure only when both stages are full and the result is stalled
  `FPR_ASSERT(a_ready_low, clk, rst, !in_ready |-> s1_valid && out_valid && !out_ready)
  // an item waiting in the input stage is neither lost nor altered
  `FPR_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !commit,
                   s1_valid && $stable(s1_byte) && $stable(s1_opcode))

endmodule

// ----- rtl/core/fpr_cfg.sv -----
// config registers on the apb-style port
module fpr_cfg import fpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_MARKER: cfg.start_marker <= pwdata[7:0];
        REG_END_MARKER:   cfg.end_marker   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_MARKER: prdata = {24'd0, cfg.start_marker};
      REG_END_MARKER:   prdata = {24'd0, cfg.end_marker};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/fpr_frame.sv -----
// frame parser state, running check and frame counters
module fpr_frame import fpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       commit,
  input  logic [1:0] opcode,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);
  `include "framed_packet_receiver_core_macros.svh"

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;
  localparam logic [2:0] PH_END   = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  length_held, length_held_next;
  logic [7:0]  data_left, data_left_next;
  logic [7:0]  running_check, running_check_next;
  logic [7:0]  command_held, command_held_next;
  logic [31:0] discard_total, discard_total_next;
  logic [31:0] master_total, master_total_next;
  logic [31:0] slave_total, slave_total_next;
  logic [2:0]  status;
  logic        slave;

  always_comb begin
    phase_next         = phase;
    length_held_next   = length_held;
    data_left_next     = data_left;
    running_check_next = running_check;
    command_held_next  = command_held;
    discard_total_next = discard_total;
    master_total_next  = master_total;
    slave_total_next   = slave_total;
    status             = ST_IN_FRAME;
    slave              = 1'b0;
    case (opcode)
      OP_CLR_DISCARD: discard_total_next = '0;
      OP_CLR_MASTER:  master_total_next  = '0;
      OP_CLR_SLAVE:   slave_total_next   = '0;
      default: begin
        case (phase)
          PH_LEN: begin
            if (rx_byte >= LEN_MIN) begin
              length_held_next   = rx_byte;
              running_check_next = running_check ^ rx_byte;
              phase_next         = PH_CMD;
            end else begin
              discard_total_next = discard_total + 32'd2;
              status             = ST_BAD_LEN;
              phase_next         = PH_START;
            end
          end
          PH_CMD: begin
            if (rx_byte > CMD_FLOOR) begin
              command_held_next  = rx_byte;
              running_check_next = running_check ^ rx_byte;
              if (length_held == LEN_MIN) begin
                phase_next = PH_CHECK;
              end else begin
                data_left_next = length_held - LEN_MIN;
                phase_next     = PH_DATA;
              end
            end else begin
              discard_total_next = discard_total + 32'd3;
              status             = ST_BAD_CMD;
              phase_next         = PH_START;
            end
          end
          PH_DATA: begin
            running_check_next = running_check ^ rx_byte;
            data_left_next     = data_left - 8'd1;
            // last data byte moves on to the check byte
            if (data_left == 8'd1) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (rx_byte == running_check) begin
              phase_next = PH_END;
            end else begin
              discard_total_next = discard_total + {24'd0, length_held} + 32'd1;
              status             = ST_BAD_CHECK;
              phase_next         = PH_START;
            end
          end
          PH_END: begin
            if (rx_byte == cfg.end_marker) begin
              status = ST_ACCEPT;
              if (is_slave(command_held, length_held)) begin
                slave            = 1'b1;
                slave_total_next = slave_total + 32'd1;
              end else begin
                master_total_next = master_total + 32'd1;
              end
            end else begin
              discard_total_next = discard_total + {24'd0, length_held} + 32'd2;
              status             = ST_BAD_END;
            end
            phase_next = PH_START;
          end
          default: begin
            if (rx_byte == cfg.start_marker) begin
              running_check_next = rx_byte;
              phase_next         = PH_LEN;
            end else begin
              discard_total_next = discard_total + 32'd1;
              status             = ST_BAD_START;
              phase_next         = PH_START;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      length_held   <= '0;
      data_left     <= '0;
      running_check <= '0;
      command_held  <= '0;
      discard_total <= '0;
      master_total  <= '0;
      slave_total   <= '0;
    end else if (commit) begin
      phase         <= phase_next;
      length_held   <= length_held_next;
      data_left     <= data_left_next;
      running_check <= running_check_next;
      command_held  <= command_held_next;
      discard_total <= discard_total_next;
      master_total  <= master_total_next;
      slave_total   <= slave_total_next;
    end
  end

  always_comb begin
    res.byte_status     = status;
    res.from_slave      = slave;
    res.command_code    = command_held_next;
    res.frame_length    = length_held_next;
    res.discarded_bytes = discard_total_next;
    res.master_frames   = master_total_next;
    res.slave_frames    = slave_total_next;
  end

  // counters move only when an item is committed
  `FPR_ASSERT_NEXT(a_discard_hold, clk, rst, !commit, $stable(discard_total))
  // clear opcodes leave the parser where it was
  `FPR_ASSERT_NEXT(a_clear_keeps_phase, clk, rst, commit && opcode != OP_RX, $stable(phase))
  // the end byte always closes the frame
  `FPR_ASSERT_NEXT(a_end_closes, clk, rst, commit && opcode == OP_RX && phase == PH_END,
                   phase == PH_START)

endmodule
